// File: rtl/mel_filterbank_log_energy_macros.svh
// Assertion macros shared by the mel filterbank RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef MEL_FILTERBANK_LOG_ENERGY_MACROS_SVH
`define MEL_FILTERBANK_LOG_ENERGY_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define MFLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define MFLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mfle_pkg.sv
// Shared types and constants for the mel filterbank log energy block.
// Used by every module of the block except mfle_ram; depends on nothing.
package mfle_pkg;

    localparam int ACC_W  = 40;
    localparam int MAG_W  = 16;
    localparam int WT_W   = 16;
    localparam int PROD_W = MAG_W + WT_W;
    localparam int LOG_W  = 16;
    localparam int MEL_W  = 4;
    localparam int WBIN_W = 9;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    // ln(2) in unsigned Q0.32.
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    typedef enum logic {
        CMD_BIN    = 1'b0,
        CMD_WEIGHT = 1'b1
    } t_cmd;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MAC    = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_EREAD  = 6'b001000,
        S_ESTART = 6'b010000,
        S_EWAIT  = 6'b100000
    } t_state;

    typedef enum logic [6:0] {
        L_IDLE   = 7'b0000001,
        L_NORM   = 7'b0000010,
        L_SQ_MUL = 7'b0000100,
        L_SQ_FIX = 7'b0001000,
        L_SC_MUL = 7'b0010000,
        L_SC_RND = 7'b0100000,
        L_DONE   = 7'b1000000
    } t_log_state;

    // One band lookup entering the multiply-accumulate pipeline.
    typedef struct packed {
        logic vld;
        logic sum_vld;
    } t_mac_ctl;

    // Status returned by the multiply-accumulate pipeline.
    typedef struct packed {
        logic we;
        logic busy;
    } t_mac_stat;

endpackage

// File: rtl/mfle_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; used for the weight table and the band sums.
module mfle_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mfle_mac.sv
// Two-stage multiply-accumulate pipeline: magnitude times weight, then a
// saturating add into the band sum. Depends on mfle_pkg.
module mfle_mac #(
    parameter int BW = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mfle_pkg::t_mac_ctl              i_ctl,
    input  logic [BW-1:0]                   i_band,
    input  logic [mfle_pkg::MAG_W-1:0]      i_mag,
    input  logic [mfle_pkg::WT_W-1:0]       i_weight,
    input  logic [mfle_pkg::ACC_W-1:0]      i_sum,
    output mfle_pkg::t_mac_stat             o_stat,
    output logic [BW-1:0]                   o_band,
    output logic [mfle_pkg::ACC_W-1:0]      o_sum
);

    localparam int AW = mfle_pkg::ACC_W;

    logic                            r_p1_vld;
    logic                            r_p1_svld;
    logic [BW-1:0]                   r_p1_band;
    logic                            r_p2_vld;
    logic [BW-1:0]                   r_p2_band;
    logic [mfle_pkg::PROD_W-1:0]     r_p2_prod;
    logic [AW-1:0]                   r_p2_sum;
    logic [AW:0]                     w_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_ctl.vld;
            r_p2_vld <= r_p1_vld;
        end
    end

    // The RAM read data is present in the cycle after the lookup was issued.
    always_ff @(posedge i_clk) begin
        r_p1_svld <= i_ctl.sum_vld;
        r_p1_band <= i_band;
        r_p2_band <= r_p1_band;
        r_p2_prod <= i_mag * i_weight;
        r_p2_sum  <= r_p1_svld ? i_sum : '0;
    end

    assign w_total     = {1'b0, r_p2_sum} + (AW + 1)'(r_p2_prod);
    assign o_sum       = w_total[AW] ? mfle_pkg::ACC_MAX : w_total[AW-1:0];
    assign o_band      = r_p2_band;
    assign o_stat.we   = r_p2_vld;
    assign o_stat.busy = r_p1_vld | r_p2_vld;

endmodule

// File: rtl/mfle_log.sv
// Iterative natural-log unit: ln(1 + acc / 2^15) in unsigned Q5.11, saturating.
// Normalizes one bit per cycle, squares for sixteen log2 bits. Depends on mfle_pkg.
`include "mel_filterbank_log_energy_macros.svh"

module mfle_log (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mfle_pkg::ACC_W-1:0]  i_acc,
    output logic                        o_done,
    output logic [mfle_pkg::LOG_W-1:0]  o_result
);

    localparam int VW = mfle_pkg::ACC_W + 1;
    localparam int LW = mfle_pkg::LOG_W;

    mfle_pkg::t_log_state r_state, n_state;
    logic [VW-1:0]  r_v, n_v;
    logic [5:0]     r_e, n_e;
    logic [30:0]    r_m, n_m;
    logic [61:0]    r_sq, n_sq;
    logic [15:0]    r_frac, n_frac;
    logic [3:0]     r_cnt, n_cnt;
    logic [52:0]    r_prod, n_prod;
    logic [LW-1:0]  r_result, n_result;
    logic [31:0]    w_sq_top;
    logic [20:0]    w_l;
    logic [53:0]    w_rnd;

    assign w_sq_top = r_sq[61:30];
    assign w_l      = {5'(r_e - 6'd15), r_frac};
    assign w_rnd    = {1'b0, r_prod} + (54'd1 << 36);

    always_comb begin
        n_state  = r_state;
        n_v      = r_v;
        n_e      = r_e;
        n_m      = r_m;
        n_sq     = r_sq;
        n_frac   = r_frac;
        n_cnt    = r_cnt;
        n_prod   = r_prod;
        n_result = r_result;
        unique case (r_state)
            mfle_pkg::L_IDLE, mfle_pkg::L_DONE: begin
            end
            mfle_pkg::L_NORM: begin
                if (r_v[VW-1]) begin
                    // Keep the top 31 bits as Q1.30.
                    n_m     = r_v[VW-1:VW-31];
                    n_cnt   = '0;
                    n_frac  = '0;
                    n_state = mfle_pkg::L_SQ_MUL;
                end else begin
                    n_v = {r_v[VW-2:0], 1'b0};
                    n_e = r_e - 6'd1;
                end
            end
            mfle_pkg::L_SQ_MUL: begin
                n_sq    = r_m * r_m;
                n_state = mfle_pkg::L_SQ_FIX;
            end
            mfle_pkg::L_SQ_FIX: begin
                // A square of two or more gives a one bit and is halved.
                if (w_sq_top[31]) begin
                    n_m = w_sq_top[31:1];
                end else begin
                    n_m = w_sq_top[30:0];
                end
                n_frac = {r_frac[14:0], w_sq_top[31]};
                n_cnt  = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = mfle_pkg::L_SC_MUL;
                end else begin
                    n_state = mfle_pkg::L_SQ_MUL;
                end
            end
            mfle_pkg::L_SC_MUL: begin
                n_prod  = w_l * mfle_pkg::LN2_Q32;
                n_state = mfle_pkg::L_SC_RND;
            end
            mfle_pkg::L_SC_RND: begin
                if (w_rnd[53]) begin
                    n_result = '1;
                end else begin
                    n_result = w_rnd[52:37];
                end
                n_state = mfle_pkg::L_DONE;
            end
            default: begin
                n_state = mfle_pkg::L_IDLE;
            end
        endcase
        if (i_start) begin
            n_v     = {1'b0, i_acc} + (VW'(1) << 15);
            n_e     = 6'(VW - 1);
            n_state = mfle_pkg::L_NORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfle_pkg::L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v      <= n_v;
        r_e      <= n_e;
        r_m      <= n_m;
        r_sq     <= n_sq;
        r_frac   <= n_frac;
        r_cnt    <= n_cnt;
        r_prod   <= n_prod;
        r_result <= n_result;
    end

    assign o_done   = (r_state == mfle_pkg::L_DONE);
    assign o_result = r_result;

    `MFLE_ASSERT_NXT(a_start_loads, i_clk, i_rst_n, i_start, (r_state == mfle_pkg::L_NORM) && (r_v >= (VW'(1) << 15)), "log start did not load a biased value")
    `MFLE_ASSERT_IMP(a_exp_floor, i_clk, i_rst_n, (r_state == mfle_pkg::L_NORM) && r_v[VW-1], r_e >= 6'd15, "normalized exponent below the bias")
    `MFLE_ASSERT_IMP(a_mant_norm, i_clk, i_rst_n, r_state == mfle_pkg::L_SQ_MUL, r_m[30], "mantissa lost normalization during squaring")

endmodule

// File: rtl/mel_filterbank_log_energy.sv
// Mel filterbank log energy. A weight write leaves the block idle and ready for the next item.
// A bin within the table depth runs one multiply-accumulate per band through the weight and
// band-sum RAMs, plus pipeline drain; a bin past the table depth adds nothing. On the last bin
// each band's ln(1 + sum / 2^15) runs in the iterative log unit (one normalize bit per cycle),
// bands in turn. Synchronous active-low reset clears control and the band-sum valid bits; the
// weight table is not cleared and needs no clearing pass.
`include "mel_filterbank_log_energy_macros.svh"

module mel_filterbank_log_energy #(
    parameter int BINS = 512,
    parameter int MELS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [mfle_pkg::MAG_W-1:0]    i_magnitude,
    input  logic                          i_last_bin,
    input  logic [mfle_pkg::WBIN_W-1:0]   i_weight_bin,
    input  logic [mfle_pkg::MEL_W-1:0]    i_weight_mel,
    input  logic [mfle_pkg::WT_W-1:0]     i_weight_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mfle_pkg::MEL_W-1:0]    o_mel_index,
    output logic [mfle_pkg::LOG_W-1:0]    o_log_energy,
    output logic                          o_last
);

    localparam int BW = (MELS > 1) ? $clog2(MELS) : 1;
    localparam int AW = $clog2(BINS * MELS);
    localparam int PW = $clog2(BINS + 1);
    localparam int MW = mfle_pkg::MEL_W;
    localparam logic [BW-1:0] LAST_BAND = BW'(MELS - 1);
    localparam logic [PW-1:0] BINS_P    = PW'(BINS);

    mfle_pkg::t_state r_state, n_state;
    logic [BW-1:0]                r_band, n_band;
    logic [AW-1:0]                r_waddr, n_waddr;
    logic [PW-1:0]                r_bin_pos, n_bin_pos;
    logic [MELS-1:0]              r_sum_vld, n_sum_vld;
    logic [mfle_pkg::MAG_W-1:0]   r_mag;
    logic                         r_last;
    logic                         r_out_valid, n_out_valid;
    logic [MW-1:0]                r_out_mel;
    logic [mfle_pkg::LOG_W-1:0]   r_out_log;
    logic                         r_out_last;

    logic                         w_accept;
    logic                         w_bin_acc;
    logic                         w_wt_we;
    logic [AW-1:0]                w_wt_waddr;
    logic [mfle_pkg::WT_W-1:0]    w_weight;
    logic [mfle_pkg::ACC_W-1:0]   w_sum_rdata;
    mfle_pkg::t_mac_ctl           w_mac_ctl;
    mfle_pkg::t_mac_stat          w_mac_stat;
    logic [BW-1:0]                w_sum_waddr;
    logic [mfle_pkg::ACC_W-1:0]   w_sum_wdata;
    logic                         w_log_start;
    logic                         w_log_done;
    logic [mfle_pkg::LOG_W-1:0]   w_log_result;
    logic                         w_out_load;

    assign o_ready   = (r_state == mfle_pkg::S_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_bin_acc = w_accept && (i_cmd == mfle_pkg::CMD_BIN);

    // Writes outside the table are dropped.
    assign w_wt_we = w_accept && (i_cmd == mfle_pkg::CMD_WEIGHT)
                     && (int'(i_weight_bin) < BINS) && (int'(i_weight_mel) < MELS);
    assign w_wt_waddr = AW'(int'(i_weight_bin) * MELS + int'(i_weight_mel));

    assign w_mac_ctl.vld     = (r_state == mfle_pkg::S_MAC);
    assign w_mac_ctl.sum_vld = r_sum_vld[r_band];
    assign w_log_start       = (r_state == mfle_pkg::S_ESTART);
    assign w_out_load        = (r_state == mfle_pkg::S_EWAIT) && w_log_done
                               && (!r_out_valid || i_ready);

    mfle_ram #(
        .WIDTH (mfle_pkg::WT_W),
        .DEPTH (BINS * MELS)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_wt_we),
        .i_waddr (w_wt_waddr),
        .i_wdata (i_weight_value),
        .i_raddr (r_waddr),
        .o_rdata (w_weight)
    );

    mfle_ram #(
        .WIDTH (mfle_pkg::ACC_W),
        .DEPTH (MELS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (w_mac_stat.we),
        .i_waddr (w_sum_waddr),
        .i_wdata (w_sum_wdata),
        .i_raddr (r_band),
        .o_rdata (w_sum_rdata)
    );

    mfle_mac #(
        .BW (BW)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_band   (r_band),
        .i_mag    (r_mag),
        .i_weight (w_weight),
        .i_sum    (w_sum_rdata),
        .o_stat   (w_mac_stat),
        .o_band   (w_sum_waddr),
        .o_sum    (w_sum_wdata)
    );

    // A band whose valid bit is clear holds zero, whatever the RAM says.
    mfle_log u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_log_start),
        .i_acc    (r_sum_vld[r_band] ? w_sum_rdata : '0),
        .o_done   (w_log_done),
        .o_result (w_log_result)
    );

    always_comb begin
        n_state   = r_state;
        n_band    = r_band;
        n_waddr   = r_waddr;
        n_bin_pos = r_bin_pos;
        n_sum_vld = r_sum_vld;
        if (w_mac_stat.we) begin
            n_sum_vld[w_sum_waddr] = 1'b1;
        end
        unique case (r_state)
            mfle_pkg::S_IDLE: begin
                if (w_bin_acc) begin
                    if (r_bin_pos < BINS_P) begin
                        n_state = mfle_pkg::S_MAC;
                    end else if (i_last_bin) begin
                        n_state = mfle_pkg::S_EREAD;
                    end
                end
            end
            mfle_pkg::S_MAC: begin
                n_waddr = r_waddr + AW'(1);
                if (r_band == LAST_BAND) begin
                    n_band    = '0;
                    n_bin_pos = r_bin_pos + PW'(1);
                    n_state   = mfle_pkg::S_DRAIN;
                end else begin
                    n_band = r_band + BW'(1);
                end
            end
            mfle_pkg::S_DRAIN: begin
                if (!w_mac_stat.busy) begin
                    n_state = r_last ? mfle_pkg::S_EREAD : mfle_pkg::S_IDLE;
                end
            end
            mfle_pkg::S_EREAD: begin
                n_state = mfle_pkg::S_ESTART;
            end
            mfle_pkg::S_ESTART: begin
                // The sum is handed to the log unit, so the band starts over at zero.
                n_sum_vld[r_band] = 1'b0;
                n_state           = mfle_pkg::S_EWAIT;
            end
            mfle_pkg::S_EWAIT: begin
                if (w_out_load) begin
                    if (r_band == LAST_BAND) begin
                        n_band    = '0;
                        n_waddr   = '0;
                        n_bin_pos = '0;
                        n_state   = mfle_pkg::S_IDLE;
                    end else begin
                        n_band  = r_band + BW'(1);
                        n_state = mfle_pkg::S_EREAD;
                    end
                end
            end
            default: begin
                n_state = mfle_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfle_pkg::S_IDLE;
            r_band      <= '0;
            r_waddr     <= '0;
            r_bin_pos   <= '0;
            r_sum_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_band      <= n_band;
            r_waddr     <= n_waddr;
            r_bin_pos   <= n_bin_pos;
            r_sum_vld   <= n_sum_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bin_acc) begin
            r_mag  <= i_magnitude;
            r_last <= i_last_bin;
        end
        if (w_out_load) begin
            r_out_mel  <= MW'(r_band);
            r_out_log  <= w_log_result;
            r_out_last <= (r_band == LAST_BAND);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_mel_index  = r_out_mel;
    assign o_log_energy = r_out_log;
    assign o_last       = r_out_last;

    `MFLE_ASSERT_IMP(a_frame_clean, i_clk, i_rst_n, (r_state == mfle_pkg::S_IDLE) && (r_bin_pos == '0), r_sum_vld == '0, "band sums not cleared between frames")
    `MFLE_ASSERT_IMP(a_mac_in_range, i_clk, i_rst_n, r_state == mfle_pkg::S_MAC, r_bin_pos < BINS_P, "accumulation past the last table row")
    `MFLE_ASSERT_IMP(a_sum_wr_phase, i_clk, i_rst_n, w_mac_stat.we, (r_state == mfle_pkg::S_MAC) || (r_state == mfle_pkg::S_DRAIN), "band sum written outside the accumulate phase")

endmodule

// File: test/tb_mel_filterbank_log_energy.sv
// Self-checking testbench for mel_filterbank_log_energy: drives weight writes and spectrum
// frames, predicts each band's log energy and compares every band transaction in order.
// Depends only on mfle_pkg and the mel_filterbank_log_energy RTL.
module tb_mel_filterbank_log_energy;

    localparam int TB_BINS      = 512;
    localparam int TB_MELS      = 16;
    localparam int LOADED_ROWS  = 4;
    localparam int RANDOM_ITEMS = 170;
    localparam int FULL_BANDS   = 2;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 1500;
    localparam int CYCLE_LIMIT  = 1500000;

    typedef logic [mfle_pkg::MAG_W-1:0]  t_mag;
    typedef logic [mfle_pkg::WBIN_W-1:0] t_wbin;
    typedef logic [mfle_pkg::MEL_W-1:0]  t_mel;
    typedef logic [mfle_pkg::WT_W-1:0]   t_wt;
    typedef logic [mfle_pkg::LOG_W-1:0]  t_log;
    typedef logic [mfle_pkg::ACC_W-1:0]  t_acc;

    typedef enum int {
        MAG_ANY,
        MAG_ZERO,
        MAG_FULL,
        MAG_LOW
    } t_mag_kind;

    typedef struct packed {
        t_mel mel;
        t_log energy;
        logic last;
    } t_band_energy;

    // Tracks the weight table and band sums and queues the log energies each frame yields.
    class mel_energy_tracker;
        t_wt          weights [TB_BINS*TB_MELS];
        t_acc         band_acc [TB_MELS];
        int unsigned  bin_pos;
        t_band_energy pending_bands [$];
        int unsigned  errors;

        function new();
            foreach (weights[i]) weights[i] = '0;
            foreach (band_acc[i]) band_acc[i] = '0;
            bin_pos = 0;
            errors  = 0;
        endfunction

        // ln(1 + acc / 2^15) in Q5.11 via log2 by repeated squaring.
        function t_log ln_q511(t_acc acc);
            logic [63:0] v;
            logic [63:0] m;
            logic [63:0] lq;
            logic [63:0] r;
            logic [15:0] frac;
            int          e;
            v = {24'd0, acc} + 64'd32768;
            e = 0;
            for (int b = 0; b < 42; b++) begin
                if (v[b]) e = b;
            end
            if (e >= 30) m = v >> (e - 30);
            else m = v << (30 - e);
            frac = '0;
            repeat (16) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m[31]) begin
                    frac[0] = 1'b1;
                    m = m >> 1;
                end
            end
            lq = 64'(e - 15);
            lq = (lq << 16) | {48'd0, frac};
            r = (lq * {32'd0, mfle_pkg::LN2_Q32} + (64'd1 << 36)) >> 37;
            return (r > 64'd65535) ? 16'hFFFF : r[15:0];
        endfunction

        function void note_item(mfle_pkg::t_cmd cmd, t_mag mag, logic last_bin,
                                t_wbin wbin, t_mel wmel, t_wt wval);
            logic [mfle_pkg::PROD_W-1:0] prod;
            logic [mfle_pkg::ACC_W:0]    sum;
            t_band_energy                band;
            if (cmd == mfle_pkg::CMD_WEIGHT) begin
                if (wbin < TB_BINS && wmel < TB_MELS) weights[wbin*TB_MELS + wmel] = wval;
                return;
            end
            // Bins past the table depth add nothing and leave the position where it is.
            if (bin_pos < TB_BINS) begin
                for (int m = 0; m < TB_MELS; m++) begin
                    prod = mag * weights[bin_pos*TB_MELS + m];
                    sum = band_acc[m] + prod;
                    band_acc[m] = sum[mfle_pkg::ACC_W] ? mfle_pkg::ACC_MAX
                                                       : sum[mfle_pkg::ACC_W-1:0];
                end
                bin_pos++;
            end
            if (last_bin) begin
                for (int m = 0; m < TB_MELS; m++) begin
                    band.mel    = t_mel'(m);
                    band.energy = ln_q511(band_acc[m]);
                    band.last   = (m == TB_MELS - 1);
                    pending_bands.push_back(band);
                    band_acc[m] = '0;
                end
                bin_pos = 0;
            end
        endfunction

        function void check_band(t_mel mel, t_log energy, logic last);
            t_band_energy want;
            if (pending_bands.size() == 0) begin
                errors++;
                $display("%0t: expected no band, got mel=%0d energy=%0d last=%0b",
                         $time, mel, energy, last);
                return;
            end
            want = pending_bands.pop_front();
            if (want.mel !== mel || want.energy !== energy || want.last !== last) begin
                errors++;
                $display("%0t: expected %0d,%0d,%0b got %0d,%0d,%0b (mel,energy,last)",
                         $time, want.mel, want.energy, want.last, mel, energy, last);
            end
        endfunction

        function int unsigned outstanding();
            return pending_bands.size();
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_ready;
    logic   i_cmd = mfle_pkg::CMD_BIN;
    t_mag   i_magnitude = '0;
    logic   i_last_bin = 1'b0;
    t_wbin  i_weight_bin = '0;
    t_mel   i_weight_mel = '0;
    t_wt    i_weight_value = '0;
    logic   o_valid;
    logic   i_ready = 1'b0;
    t_mel   o_mel_index;
    t_log   o_log_energy;
    logic   o_last;

    mel_energy_tracker energy_tracker;
    int                idle_level = 0;
    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;
    int unsigned       items_accepted = 0;
    int unsigned       rows_loaded = 0;
    int unsigned       cycle_count = 0;

    mel_filterbank_log_energy #(
        .BINS (TB_BINS),
        .MELS (TB_MELS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_magnitude    (i_magnitude),
        .i_last_bin     (i_last_bin),
        .i_weight_bin   (i_weight_bin),
        .i_weight_mel   (i_weight_mel),
        .i_weight_value (i_weight_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mel_index    (o_mel_index),
        .o_log_energy   (o_log_energy),
        .o_last         (o_last)
    );

    initial begin
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** mel_filterbank_log_energy: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            energy_tracker.check_band(o_mel_index, o_log_energy, o_last);
    end

    // Band receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
                i_ready <= 1'b1;
            end else if (idle_level != 0 && $urandom_range(0, 12 - 4*idle_level) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(mfle_pkg::t_cmd cmd, t_mag mag, logic last_bin,
                             t_wbin wbin, t_mel wmel, t_wt wval);
        if (idle_level != 0 && $urandom_range(0, 12 - 4*idle_level) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_magnitude    <= mag;
        i_last_bin     <= last_bin;
        i_weight_bin   <= wbin;
        i_weight_mel   <= wmel;
        i_weight_value <= wval;
        do @(posedge i_clk); while (!o_ready);
        energy_tracker.note_item(cmd, mag, last_bin, wbin, wmel, wval);
        items_accepted++;
    endtask

    // Magnitude and last_bin are don't-care on a weight write, so they carry noise.
    task automatic write_weight(t_wbin row, t_mel band, t_wt value);
        send_item(mfle_pkg::CMD_WEIGHT, t_mag'($urandom), 1'($urandom_range(0, 1)),
                  row, band, value);
    endtask

    function automatic t_wt pick_weight();
        unique case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            3: return t_wt'($urandom_range(32769, 65535));
            default: return t_wt'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic t_mag pick_mag(t_mag_kind kind);
        unique case (kind)
            MAG_ZERO: return '0;
            MAG_FULL: return 16'hFFFF;
            MAG_LOW:  return t_mag'($urandom_range(0, 15));
            default:  return ($urandom_range(0, 9) == 0) ? 16'hFFFF : t_mag'($urandom);
        endcase
    endfunction

    task automatic load_rows(int first, int count, int full_bands);
        for (int row = first; row < first + count; row++) begin
            for (int band = 0; band < TB_MELS; band++) begin
                write_weight(t_wbin'(row), t_mel'(band),
                             (band < full_bands) ? 16'hFFFF : pick_weight());
            end
        end
    endtask

    // Weight fields on a bin are don't-care; rewrites may land mid-frame.
    task automatic send_frame(int nbins, t_mag_kind kind, int rewrite_pct);
        for (int i = 0; i < nbins; i++) begin
            if ($urandom_range(0, 99) < rewrite_pct)
                write_weight(t_wbin'($urandom_range(0, rows_loaded - 1)), t_mel'($urandom),
                             pick_weight());
            send_item(mfle_pkg::CMD_BIN, pick_mag(kind), i == nbins - 1,
                      t_wbin'($urandom), t_mel'($urandom), t_wt'($urandom));
        end
    endtask

    initial begin
        int unsigned first_random;
        energy_tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_level = 1;
        load_rows(0, LOADED_ROWS, FULL_BANDS);
        rows_loaded = LOADED_ROWS;
        send_frame(1, MAG_ZERO, 0);
        send_frame(1, MAG_FULL, 0);
        send_frame(2, MAG_LOW, 0);
        send_frame(LOADED_ROWS, MAG_FULL, 0);
        send_frame(4, MAG_ANY, 50);

        // Hold the receiver off while short frames keep coming, so the block backs up.
        idle_level = 0;
        hold_req = 1'b1;
        repeat (12) send_frame($urandom_range(1, 2), MAG_ANY, 0);

        first_random = items_accepted;
        while (items_accepted - first_random < RANDOM_ITEMS) begin
            idle_level = $urandom_range(0, 2);
            if ($urandom_range(0, 4) == 0)
                write_weight(t_wbin'($urandom_range(0, rows_loaded - 1)), t_mel'($urandom),
                             pick_weight());
            else
                send_frame($urandom_range(1, rows_loaded),
                           t_mag_kind'($urandom_range(0, 3)), 15);
        end

        // The closing frames run back to back without idling; the second one checks
        // that the sums of the first were cleared.
        idle_level = 0;
        send_frame(LOADED_ROWS, MAG_FULL, 0);
        send_frame(2, MAG_ANY, 0);
        i_valid <= 1'b0;

        while (energy_tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (energy_tracker.errors == 0)
            $display("** mel_filterbank_log_energy: PASSED **");
        else
            $display("** mel_filterbank_log_energy: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/mfle_pkg.sv
rtl/mfle_ram.sv
rtl/mfle_mac.sv
rtl/mfle_log.sv
rtl/mel_filterbank_log_energy.sv
test/tb_mel_filterbank_log_energy.sv
